/* rtl/ipid_pkg.sv */
// ipid_pkg: shared constants, register indexes and ALU operation codes
// for the incremental PID controller. No dependencies.
package ipid_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_KP  = 2'd0,
    REG_TI  = 2'd1,
    REG_TD  = 2'd2,
    REG_SRC = 2'd3
  } reg_idx_e;

  // operation codes for the serial arithmetic unit
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } alu_op_e;

endpackage

/* rtl/ipid_alu.sv */
// ipid_alu: bit-serial signed fixed-point multiply and divide with saturation.
// Depends on ipid_pkg. One quotient or multiplier bit per cycle.
module ipid_alu #(
  parameter int unsigned DataWidth = 32,
  parameter int unsigned FracBits  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  ipid_pkg::alu_op_e           op_i,
  input  logic signed [DataWidth-1:0] a_i,
  input  logic signed [DataWidth-1:0] b_i,
  output logic                        done_o,
  output logic signed [DataWidth-1:0] res_o,
  output logic                        clip_o
);
  import ipid_pkg::*;

  localparam int unsigned PW = 2 * DataWidth;              // product width
  localparam int unsigned NW = DataWidth + FracBits;       // dividend width
  localparam int unsigned CW = $clog2(NW + 1);
  localparam int unsigned RW = PW + 1;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_PACK} st_e;

  st_e                  st_q;
  alu_op_e              op_q;
  logic [CW-1:0]        cnt_q;
  logic                 neg_q;
  logic [PW-1:0]        acc_q;    // product, or quotient bits shifted in
  logic [DataWidth-1:0] mcand_q;  // multiplicand or divisor magnitude
  logic [NW-1:0]        shf_q;    // multiplier bits, or dividend bits
  logic [DataWidth:0]   rem_q;
  logic                 done_q;
  logic signed [DataWidth-1:0] res_q;
  logic                 clip_q;

  logic [DataWidth-1:0] ma, mb;
  logic [DataWidth:0]   rsh, rdiff;
  logic [RW-1:0]        mul_sum;
  logic [PW-1:0]        prod_sh;
  logic [DataWidth-1:0] lim_pos, lim_neg;
  logic                 ovf;
  logic [DataWidth-1:0] mag;

  assign ma = a_i[DataWidth-1] ? DataWidth'(-a_i) : DataWidth'(a_i);
  assign mb = b_i[DataWidth-1] ? DataWidth'(-b_i) : DataWidth'(b_i);

  // shift-add multiplier, MSB first
  assign mul_sum = {acc_q, 1'b0} + (shf_q[NW-1] ? RW'(mcand_q) : RW'(0));
  // restoring division step
  assign rsh   = {rem_q[DataWidth-1:0], shf_q[NW-1]};
  assign rdiff = rsh - {1'b0, mcand_q};

  assign lim_pos = {1'b0, {(DataWidth-1){1'b1}}};
  assign lim_neg = {1'b1, {(DataWidth-1){1'b0}}};
  assign prod_sh = (op_q == OP_MUL) ? (acc_q >> FracBits) : acc_q;
  assign ovf = (prod_sh[PW-1:DataWidth] != '0) ||
               (prod_sh[DataWidth-1:0] > (neg_q ? lim_neg : lim_pos));
  assign mag = prod_sh[DataWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
      clip_q <= 1'b0;
    end else begin
      unique case (st_q)
        S_IDLE: begin
          // a divide by zero finishes at once
          done_q <= start_i && (op_i == OP_DIV) && (mb == '0);
          if (start_i) begin
            op_q    <= op_i;
            neg_q   <= a_i[DataWidth-1] ^ b_i[DataWidth-1];
            acc_q   <= '0;
            rem_q   <= '0;
            if (op_i == OP_MUL) begin
              mcand_q <= ma;
              shf_q   <= {mb, {FracBits{1'b0}}};
              cnt_q   <= CW'(DataWidth);
              st_q    <= S_MUL;
            end else if (mb == '0) begin
              res_q  <= (ma == '0) ? '0 : (a_i[DataWidth-1] ? lim_neg : lim_pos);
              clip_q <= (ma != '0);
            end else begin
              mcand_q <= mb;
              shf_q   <= {ma, {FracBits{1'b0}}};
              cnt_q   <= CW'(NW);
              st_q    <= S_DIV;
            end
          end
        end
        S_MUL: begin
          acc_q <= mul_sum[PW-1:0];
          shf_q <= shf_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) st_q <= S_PACK;
        end
        S_DIV: begin
          if (!rdiff[DataWidth]) begin
            rem_q <= rdiff;
            acc_q <= {acc_q[PW-2:0], 1'b1};
          end else begin
            rem_q <= rsh;
            acc_q <= {acc_q[PW-2:0], 1'b0};
          end
          shf_q <= shf_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) st_q <= S_PACK;
        end
        S_PACK: begin
          if (ovf) begin
            res_q  <= neg_q ? lim_neg : lim_pos;
            clip_q <= 1'b1;
          end else begin
            res_q  <= neg_q ? DataWidth'(-mag) : mag;
            clip_q <= 1'b0;
          end
          done_q <= 1'b1;
          st_q   <= S_IDLE;
        end
        default: begin
          done_q <= 1'b0;
          st_q   <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign clip_o = clip_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q || $past(start_i))
    else $error("alu done held without new start");
  a_clip_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && clip_q) |-> (res_q == lim_pos || res_q == lim_neg))
    else $error("clipped result not at a limit");
  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_PACK) |=> st_q == S_IDLE)
    else $error("pack not followed by idle");

endmodule

/* rtl/incremental_pid_controller.sv */
// incremental_pid_controller: velocity-form PID top level, APB register file,
// sequencer over the serial arithmetic unit. Depends on ipid_pkg, ipid_alu.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------------
//  in       | sink      | in_valid_i / in_stall_o  | error_sample, measured_derivative,
//           |           |                          | sample_period
//  out      | source    | out_valid_o / out_stall_i| control_value, saturated
//  apb      | slave     | psel/penable/pwrite      | paddr, pwdata, prdata
//
// One beat at a time. Multiplies and divides share the bit-serial unit, and a
// beat needs up to five multiplies and two divides. in_stall_o is high from
// acceptance until the result beat leaves the output register. Reset sets
// stage 1, clears all history and loads Kp = 1.0. A stalled output simply
// holds its beat.
module incremental_pid_controller #(
  parameter int unsigned DATA_WIDTH = ipid_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = ipid_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] error_sample_i,
  input  logic signed [DATA_WIDTH-1:0] measured_derivative_i,
  input  logic [DATA_WIDTH-2:0]        sample_period_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] control_value_o,
  output logic                         saturated_o
);
  import ipid_pkg::*;

  localparam int unsigned W = DATA_WIDTH;
  typedef logic signed [W-1:0] word_t;

  // micro-ops: the sequencer walks a small program per beat
  typedef enum logic [4:0] {
    Q_IDLE, Q_SEL,
    Q_KPE, Q_KPE_W,       // p = Kp*e  (or Kp*(e-e1) in stage 3)
    Q_IM1, Q_IM1_W,       // t1 = T*x
    Q_ID,  Q_ID_W,        // t1 = t1/Ti
    Q_IK,  Q_IK_W,        // i = Kp*t1
    Q_DM1, Q_DM1_W,       // t1 = Td*x
    Q_DD,  Q_DD_W,        // t1 = t1/T (skipped for external source unless Ti is zero)
    Q_DK,  Q_DK_W,        // d = Kp*t1
    Q_SUM, Q_OUT
  } seq_e;

  word_t kp_q;
  logic [W-2:0] ti_q, td_q;
  logic src_q;
  logic [1:0] stage_q;
  word_t e1_q, e2_q, pd_q, u_q;

  word_t e_q, dm_q;
  logic [W-2:0] t_q;
  seq_e  seq_q;
  word_t p_q, i_q, d_q, t1_q, ix_q, dx_q;
  logic  use_i_q, use_d_q, clip_q;
  logic  out_v_q;
  word_t out_u_q;
  logic  out_s_q;

  logic  alu_start;
  alu_op_e alu_op;
  word_t alu_a, alu_b, alu_res;
  logic  alu_done, alu_clip;

  word_t lim_pos, lim_neg;
  assign lim_pos = {1'b0, {(W-1){1'b1}}};
  assign lim_neg = {1'b1, {(W-1){1'b0}}};

  // saturating add; returns {clip, sum}
  function automatic logic [W:0] sat_add(input word_t a, input word_t b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return {1'b1, s[W] ? lim_neg : lim_pos};
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W:0] sat_sub(input word_t a, input word_t b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return {1'b1, s[W] ? lim_neg : lim_pos};
    return {1'b0, s[W-1:0]};
  endfunction

  // APB
  logic wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= word_t'(1) <<< FRAC_BITS;
      ti_q  <= '0;
      td_q  <= '0;
      src_q <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_KP:  kp_q  <= word_t'(pwdata);
        REG_TI:  ti_q  <= (W-1)'(pwdata);
        REG_TD:  td_q  <= (W-1)'(pwdata);
        REG_SRC: src_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_KP:  prdata = 32'(kp_q);
      REG_TI:  prdata = 32'(ti_q);
      REG_TD:  prdata = 32'(td_q);
      REG_SRC: prdata = 32'(src_q);
      default: prdata = '0;
    endcase
  end

  // operand selection for each micro-op start state
  always_comb begin
    alu_start = 1'b0;
    alu_op    = OP_MUL;
    alu_a     = kp_q;
    alu_b     = e_q;
    unique case (seq_q)
      Q_KPE: begin alu_start = 1'b1; alu_b = ix_q; end
      Q_IM1: begin alu_start = 1'b1; alu_a = word_t'({1'b0, t_q}); alu_b = dx_q; end
      Q_ID:  begin alu_start = 1'b1; alu_op = OP_DIV; alu_a = t1_q;
                   alu_b = word_t'({1'b0, ti_q}); end
      Q_IK:  begin alu_start = 1'b1; alu_b = t1_q; end
      Q_DM1: begin alu_start = 1'b1; alu_a = word_t'({1'b0, td_q}); alu_b = ix_q; end
      Q_DD:  begin alu_start = 1'b1; alu_op = OP_DIV; alu_a = t1_q;
                   alu_b = word_t'({1'b0, t_q}); end
      Q_DK:  begin alu_start = 1'b1; alu_b = t1_q; end
      default: ;
    endcase
  end

  ipid_alu #(.DataWidth(W), .FracBits(FRAC_BITS)) u_alu (
    .clk_i, .rst_ni,
    .start_i(alu_start), .op_i(alu_op), .a_i(alu_a), .b_i(alu_b),
    .done_o(alu_done), .res_o(alu_res), .clip_o(alu_clip)
  );

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = (seq_q != Q_IDLE) || out_v_q;

  // operand prep (sat add chain, combinational on narrow set)
  logic [W:0] r_sub1, r_add1, r_ee2, r_e1e1, r_dd, r_dmp;
  assign r_sub1 = sat_sub(e_q, e1_q);
  assign r_add1 = sat_add(e_q, e1_q);
  assign r_ee2  = sat_add(e_q, e2_q);
  assign r_e1e1 = sat_add(e1_q, e1_q);
  assign r_dd   = sat_sub(r_ee2[W-1:0], r_e1e1[W-1:0]);
  assign r_dmp  = sat_sub(dm_q, pd_q);

  logic [W:0] s1, s2, s3;
  logic st3, pd_path;
  assign pd_path = (ti_q == '0);
  assign st3 = !pd_path && (stage_q != 2'd1) && (stage_q != 2'd2);
  assign s1 = st3 ? sat_add(u_q, p_q) : {1'b0, p_q};
  assign s2 = use_i_q ? sat_add(s1[W-1:0], i_q) : s1;
  assign s3 = use_d_q ? sat_add(s2[W-1:0], d_q) : s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= Q_IDLE;
      stage_q <= 2'd1;
      e1_q    <= '0;
      e2_q    <= '0;
      pd_q    <= '0;
      u_q     <= '0;
      out_v_q <= 1'b0;
      use_i_q <= 1'b0;
      use_d_q <= 1'b0;
      clip_q  <= 1'b0;
    end else begin
      if (out_acc) out_v_q <= 1'b0;
      unique case (seq_q)
        Q_IDLE: if (in_acc) begin
          e_q    <= error_sample_i;
          dm_q   <= measured_derivative_i;
          t_q    <= sample_period_i;
          clip_q <= 1'b0;
          seq_q  <= Q_SEL;
        end
        Q_SEL: begin
          // pick terms and their arguments
          use_i_q <= !pd_path;
          use_d_q <= (stage_q != 2'd1);
          ix_q    <= st3 ? r_sub1[W-1:0] : e_q;
          dx_q    <= (!pd_path && stage_q == 2'd2) ? r_add1[W-1:0] : e_q;
          if (pd_path) begin
            if (stage_q != 2'd1) clip_q <= r_sub1[W];
          end else if (stage_q == 2'd2) begin
            clip_q <= r_add1[W] | (!src_q & r_sub1[W]);
          end else if (stage_q != 2'd1) begin
            clip_q <= r_sub1[W] | (!src_q & (r_ee2[W] | r_e1e1[W] | r_dd[W]))
                      | (src_q & r_dmp[W]);
          end
          seq_q <= Q_KPE;
        end
        Q_KPE: seq_q <= Q_KPE_W;
        Q_KPE_W: if (alu_done) begin
          p_q    <= alu_res;
          clip_q <= clip_q | alu_clip;
          ix_q   <= src_q && !pd_path ? (stage_q == 2'd2 ? dm_q : r_dmp[W-1:0])
                  : (pd_path || stage_q == 2'd2 ? r_sub1[W-1:0] : r_dd[W-1:0]);
          if (use_i_q) seq_q <= Q_IM1;
          else if (use_d_q) seq_q <= Q_DM1;
          else seq_q <= Q_SUM;
        end
        Q_IM1: seq_q <= Q_IM1_W;
        Q_IM1_W: if (alu_done) begin
          t1_q <= alu_res; clip_q <= clip_q | alu_clip; seq_q <= Q_ID;
        end
        Q_ID: seq_q <= Q_ID_W;
        Q_ID_W: if (alu_done) begin
          t1_q <= alu_res; clip_q <= clip_q | alu_clip; seq_q <= Q_IK;
        end
        Q_IK: seq_q <= Q_IK_W;
        Q_IK_W: if (alu_done) begin
          i_q <= alu_res; clip_q <= clip_q | alu_clip;
          seq_q <= use_d_q ? Q_DM1 : Q_SUM;
        end
        Q_DM1: seq_q <= Q_DM1_W;
        Q_DM1_W: if (alu_done) begin
          t1_q <= alu_res; clip_q <= clip_q | alu_clip;
          seq_q <= (src_q && !pd_path) ? Q_DK : Q_DD;
        end
        Q_DD: seq_q <= Q_DD_W;
        Q_DD_W: if (alu_done) begin
          t1_q <= alu_res; clip_q <= clip_q | alu_clip; seq_q <= Q_DK;
        end
        Q_DK: seq_q <= Q_DK_W;
        Q_DK_W: if (alu_done) begin
          d_q <= alu_res; clip_q <= clip_q | alu_clip; seq_q <= Q_SUM;
        end
        Q_SUM: begin
          u_q     <= s3[W-1:0];
          out_u_q <= s3[W-1:0];
          out_s_q <= clip_q | s1[W] | (use_i_q & s2[W]) | (use_d_q & s3[W]);
          e2_q    <= (pd_path || stage_q != 2'd1) ? e1_q : e2_q;
          e1_q    <= e_q;
          if (!pd_path && src_q && stage_q != 2'd1) pd_q <= dm_q;
          if (stage_q == 2'd1) stage_q <= 2'd2;
          else if (!pd_path && stage_q == 2'd2) stage_q <= 2'd3;
          seq_q <= Q_OUT;
        end
        Q_OUT: begin
          out_v_q <= 1'b1;
          seq_q   <= Q_IDLE;
        end
        default: seq_q <= Q_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_v_q;
  assign control_value_o = out_u_q;
  assign saturated_o     = out_s_q;

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> in_stall_o)
    else $error("input taken while result pending");
  a_stage_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q != 2'd0)
    else $error("stage zero reached");
  a_out_after_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(seq_q) == Q_OUT)
    else $error("result raised outside output step");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |=> out_v_q && $stable(out_u_q))
    else $error("stalled result changed");

endmodule
